/* sv/rti_pkg.sv */
// ----------------------------------------------------------------------------
// rti_pkg
// Shared types and widths of the ray-triangle intersection pipeline.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int unsigned COORD_W  = 32;
  localparam int unsigned TRI_W    = 10;
  localparam int unsigned CORNER_W = 2;
  localparam int unsigned EDGE_W   = 33;
  localparam int unsigned CROSS_W  = 66;
  localparam int unsigned DOT_W    = 101;
  localparam int unsigned EPS_W    = 63;

  localparam logic [EPS_W-1:0] EPS_RESET = 63'd28147497671;

  localparam logic [CORNER_W-1:0] CORNER_0 = 2'd0;
  localparam logic [CORNER_W-1:0] CORNER_1 = 2'd1;
  localparam logic [CORNER_W-1:0] CORNER_2 = 2'd2;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_TEST  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    REASON_HIT      = 3'd0,
    REASON_PARALLEL = 3'd1,
    REASON_U_OUT    = 3'd2,
    REASON_V_OUT    = 3'd3,
    REASON_T_OUT    = 3'd4
  } reason_e;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } vec3_t;

  typedef struct packed {
    vec3_t              org;
    vec3_t              dir;
    logic [COORD_W-1:0] rmin;
    logic [COORD_W-1:0] rmax;
  } ray_t;

  typedef struct packed {
    logic               valid;
    reason_e            reason;
    logic [DOT_W-1:0]   det;
    logic [DOT_W-1:0]   nt;
    logic [COORD_W-1:0] rmin;
    logic [COORD_W-1:0] rmax;
  } classify_t;

  typedef struct packed {
    logic               valid;
    logic               hit;
    reason_e            reason;
    logic [COORD_W-1:0] distance;
  } result_t;

endpackage

/* sv/ray_triangle_intersect.sv */
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Fixed-point ray-triangle intersection engine with a triangle corner store.
//
//   channel  | dir | handshake                     | content
//   ---------+-----+-------------------------------+---------------------------
//   s_axis   | in  | s_axis_tvalid / s_axis_tready | corner write or ray test
//   m_axis   | out | m_axis_tvalid / m_axis_tready | hit, reason, distance
//   cfg      | in  | cfg_valid_i / cfg_ready_o     | determinant epsilon
//
// One item per cycle while the skid entry is empty; a test result passes the
// 31 quotient stages of the division and the split dot products.
// Corner writes give no result. Reset clears valid bits and reloads the
// epsilon, not the corner store. An output register plus a skid entry
// decouple the sides; a full skid entry holds the whole pipeline.
// ----------------------------------------------------------------------------
module ray_triangle_intersect #(
  parameter int unsigned MAX_TRIANGLES   = 1024,
  parameter int unsigned COORD_FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // tri_index, corner, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
  // range_min, range_max, zero fill
  input  logic [271:0]              s_axis_tdata,
  // operation
  input  logic [0:0]                s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // hit, reject_reason, hit_distance, zero fill
  output logic [39:0]               m_axis_tdata,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [rti_pkg::EPS_W-1:0] cfg_data_i
);

  logic                         en;
  logic                         in_xfer;
  logic [rti_pkg::TRI_W-1:0]    in_tri;
  logic [rti_pkg::CORNER_W-1:0] in_corner;
  rti_pkg::ray_t                in_ray;

  logic                         ray_a_vld_q, ray_b_vld_q;
  rti_pkg::ray_t                ray_a_q, ray_b_q;
  logic [rti_pkg::EPS_W-1:0]    eps_q;
  rti_pkg::vec3_t               c0, c1, c2;
  rti_pkg::classify_t           cls;
  rti_pkg::result_t             res;

  logic                         out_vld_q, out_vld_d, skid_vld_q, skid_vld_d, out_take;
  rti_pkg::result_t             out_q, out_d, skid_q, skid_d;

  assign en            = !skid_vld_q;
  assign s_axis_tready = en;
  assign in_xfer       = s_axis_tvalid && en;
  assign cfg_ready_o   = 1'b1;

  assign in_tri     = s_axis_tdata[9:0];
  assign in_corner  = s_axis_tdata[11:10];
  assign in_ray     = '{org:  '{x: s_axis_tdata[43:12],
                                y: s_axis_tdata[75:44],
                                z: s_axis_tdata[107:76]},
                        dir:  '{x: s_axis_tdata[139:108],
                                y: s_axis_tdata[171:140],
                                z: s_axis_tdata[203:172]},
                        rmin: s_axis_tdata[235:204],
                        rmax: s_axis_tdata[267:236]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= rti_pkg::EPS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      eps_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ray_a_vld_q <= 1'b0;
      ray_b_vld_q <= 1'b0;
    end else if (en) begin
      ray_a_vld_q <= in_xfer && (s_axis_tuser == rti_pkg::OP_TEST);
      ray_b_vld_q <= ray_a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ray_a_q <= in_ray;
      ray_b_q <= ray_a_q;
    end
  end

  rti_corner_store #(
    .MAX_TRIANGLES(MAX_TRIANGLES)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .wr_i     (in_xfer && (s_axis_tuser == rti_pkg::OP_WRITE)),
    .tri_i    (in_tri),
    .corner_i (in_corner),
    .data_i   (in_ray.org),
    .c0_o     (c0),
    .c1_o     (c1),
    .c2_o     (c2)
  );

  rti_vector_unit u_vec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ray_b_vld_q),
    .c0_i    (c0),
    .c1_i    (c1),
    .c2_i    (c2),
    .ray_i   (ray_b_q),
    .eps_i   (eps_q),
    .cls_o   (cls)
  );

  rti_divider #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .cls_i  (cls),
    .res_o  (res)
  );

  always_comb begin
    out_take   = !out_vld_q || m_axis_tready;
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    skid_vld_d = skid_vld_q;
    skid_d     = skid_q;
    priority if (skid_vld_q) begin
      if (out_take) begin
        out_d      = skid_q;
        out_vld_d  = 1'b1;
        skid_vld_d = 1'b0;
      end
    end else if (res.valid) begin
      if (out_take) begin
        out_d     = res;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = res;
        skid_vld_d = 1'b1;
      end
    end else if (out_take) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, out_q.distance, out_q.reason, out_q.hit};

endmodule

/* sv/rti_corner_store.sv */
// ----------------------------------------------------------------------------
// rti_corner_store
// Triangle corner memories, one row per triangle and corner, with slot
// index reduction.
// ----------------------------------------------------------------------------
module rti_corner_store #(
  parameter int unsigned MAX_TRIANGLES = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         wr_i,
  input  logic [rti_pkg::TRI_W-1:0]    tri_i,
  input  logic [rti_pkg::CORNER_W-1:0] corner_i,
  input  rti_pkg::vec3_t               data_i,
  output rti_pkg::vec3_t               c0_o,
  output rti_pkg::vec3_t               c1_o,
  output rti_pkg::vec3_t               c2_o
);

  localparam int unsigned TW       = rti_pkg::TRI_W;
  localparam int unsigned IDX_W    = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int unsigned RECIP_SH = 21;
  localparam int unsigned RECIP    = ((1 << RECIP_SH) + MAX_TRIANGLES - 1) / MAX_TRIANGLES;
  localparam int unsigned PROD_W   = RECIP_SH + TW;
  localparam logic [TW-1:0] MOD_C  = TW'(MAX_TRIANGLES);

  logic                         wr_q;
  logic [TW-1:0]                tri_q;
  logic [TW-1:0]                quo_q;
  logic [rti_pkg::CORNER_W-1:0] corner_q;
  rti_pkg::vec3_t               data_q;
  logic [PROD_W-1:0]            prod;
  logic [TW-1:0]                rem;
  logic [IDX_W-1:0]             idx;

  rti_pkg::vec3_t mem0 [MAX_TRIANGLES];
  rti_pkg::vec3_t mem1 [MAX_TRIANGLES];
  rti_pkg::vec3_t mem2 [MAX_TRIANGLES];
  rti_pkg::vec3_t rd0_q, rd1_q, rd2_q;

  assign prod = PROD_W'(tri_i) * PROD_W'(RECIP);
  assign rem  = tri_q - TW'(quo_q * MOD_C);
  assign idx  = IDX_W'(rem);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
    end else if (en_i) begin
      wr_q <= wr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tri_q    <= tri_i;
      quo_q    <= prod[PROD_W-1:RECIP_SH];
      corner_q <= corner_i;
      data_q   <= data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && wr_q) begin
      unique case (corner_q)
        rti_pkg::CORNER_0: mem0[idx] <= data_q;
        rti_pkg::CORNER_1: mem1[idx] <= data_q;
        rti_pkg::CORNER_2: mem2[idx] <= data_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rd0_q <= mem0[idx];
      rd1_q <= mem1[idx];
      rd2_q <= mem2[idx];
    end
  end

  assign c0_o = rd0_q;
  assign c1_o = rd1_q;
  assign c2_o = rd2_q;

endmodule

/* sv/rti_vector_unit.sv */
// ----------------------------------------------------------------------------
// rti_vector_unit
// Edges, cross products, split dot products, sign normalization and
// classification of the determinant and barycentric numerators.
// ----------------------------------------------------------------------------
module rti_vector_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  rti_pkg::vec3_t            c0_i,
  input  rti_pkg::vec3_t            c1_i,
  input  rti_pkg::vec3_t            c2_i,
  input  rti_pkg::ray_t             ray_i,
  input  logic [rti_pkg::EPS_W-1:0] eps_i,
  output rti_pkg::classify_t        cls_o
);

  localparam int unsigned EW    = rti_pkg::EDGE_W;
  localparam int unsigned CW    = rti_pkg::CROSS_W;
  localparam int unsigned DW    = rti_pkg::DOT_W;
  localparam int unsigned SPLIT = CW / 2;
  localparam int unsigned HPW   = EW + CW - SPLIT;
  localparam int unsigned LPW   = EW + SPLIT + 1;
  localparam int unsigned DEPTH = 7;
  localparam int NXT [3] = '{1, 2, 0};
  localparam int PRV [3] = '{2, 0, 1};

  logic        vld_q  [DEPTH];
  logic [31:0] rmin_q [DEPTH];
  logic [31:0] rmax_q [DEPTH];

  logic [31:0] c0a [3], c1a [3], c2a [3], orga [3], dira [3];
  logic signed [EW-1:0] e1_d [3], e2_d [3], tv_d [3], dir_d [3];
  logic signed [EW-1:0] s1_e1_q [3], s1_e2_q [3], s1_tv_q [3], s1_dir_q [3];
  logic signed [EW-1:0] s2_e1_q [3], s2_e2_q [3], s2_tv_q [3], s2_dir_q [3];
  logic signed [EW-1:0] s3_e1_q [3], s3_e2_q [3], s3_tv_q [3], s3_dir_q [3];
  logic signed [CW-1:0] pa_d [3], pb_d [3], qa_d [3], qb_d [3];
  logic signed [CW-1:0] s2_pa_q [3], s2_pb_q [3], s2_qa_q [3], s2_qb_q [3];
  logic [CW-1:0]        s3_p_q [3], s3_q_q [3];

  logic signed [EW-1:0]  op_a [4][3];
  logic [CW-1:0]         op_b [4][3];
  logic signed [HPW-1:0] hp_d [4][3], s4_hp_q [4][3];
  logic signed [LPW-1:0] lp_d [4][3], s4_lp_q [4][3];
  logic [DW-1:0]         term_d [4][3], s5_term_q [4][3];
  logic [DW-1:0]         s6_sum_q [4];
  logic [DW-1:0]         s7_n_q [4];

  logic [DW-1:0]    det, nu, nv, nt, uv;
  rti_pkg::reason_e reason_d;

  logic             cls_vld_q;
  rti_pkg::reason_e cls_reason_q;
  logic [DW-1:0]    cls_det_q, cls_nt_q;
  logic [31:0]      cls_rmin_q, cls_rmax_q;

  always_comb begin
    c0a  = '{c0_i.x, c0_i.y, c0_i.z};
    c1a  = '{c1_i.x, c1_i.y, c1_i.z};
    c2a  = '{c2_i.x, c2_i.y, c2_i.z};
    orga = '{ray_i.org.x, ray_i.org.y, ray_i.org.z};
    dira = '{ray_i.dir.x, ray_i.dir.y, ray_i.dir.z};
    for (int k = 0; k < 3; k++) begin
      e1_d[k]  = {c1a[k][31], c1a[k]} - {c0a[k][31], c0a[k]};
      e2_d[k]  = {c2a[k][31], c2a[k]} - {c0a[k][31], c0a[k]};
      tv_d[k]  = {orga[k][31], orga[k]} - {c0a[k][31], c0a[k]};
      dir_d[k] = {dira[k][31], dira[k]};
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pa_d[k] = s1_dir_q[NXT[k]] * s1_e2_q[PRV[k]];
      pb_d[k] = s1_dir_q[PRV[k]] * s1_e2_q[NXT[k]];
      qa_d[k] = s1_tv_q[NXT[k]] * s1_e1_q[PRV[k]];
      qb_d[k] = s1_tv_q[PRV[k]] * s1_e1_q[NXT[k]];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      op_a[0][k] = s3_e1_q[k];
      op_b[0][k] = s3_p_q[k];
      op_a[1][k] = s3_tv_q[k];
      op_b[1][k] = s3_p_q[k];
      op_a[2][k] = s3_dir_q[k];
      op_b[2][k] = s3_q_q[k];
      op_a[3][k] = s3_e2_q[k];
      op_b[3][k] = s3_q_q[k];
    end
    for (int d = 0; d < 4; d++) begin
      for (int k = 0; k < 3; k++) begin
        hp_d[d][k]   = op_a[d][k] * $signed(op_b[d][k][CW-1:SPLIT]);
        lp_d[d][k]   = op_a[d][k] * $signed({1'b0, op_b[d][k][SPLIT-1:0]});
        term_d[d][k] = {{(DW-HPW-SPLIT){s4_hp_q[d][k][HPW-1]}}, s4_hp_q[d][k],
                        {SPLIT{1'b0}}}
                     + {{(DW-LPW){s4_lp_q[d][k][LPW-1]}}, s4_lp_q[d][k]};
      end
    end
  end

  always_comb begin
    det = s7_n_q[0];
    nu  = s7_n_q[1];
    nv  = s7_n_q[2];
    nt  = s7_n_q[3];
    uv  = nu + nv;
    priority if (det == '0 || det < DW'(eps_i)) begin
      reason_d = rti_pkg::REASON_PARALLEL;
    end else if (nu[DW-1] || $signed(det) < $signed(nu)) begin
      reason_d = rti_pkg::REASON_U_OUT;
    end else if (nv[DW-1] || $signed(det) < $signed(uv)) begin
      reason_d = rti_pkg::REASON_V_OUT;
    end else begin
      reason_d = rti_pkg::REASON_HIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        vld_q[i] <= 1'b0;
      end
      cls_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int i = 1; i < DEPTH; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
      cls_vld_q <= vld_q[DEPTH-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rmin_q[0] <= ray_i.rmin;
      rmax_q[0] <= ray_i.rmax;
      for (int i = 1; i < DEPTH; i++) begin
        rmin_q[i] <= rmin_q[i-1];
        rmax_q[i] <= rmax_q[i-1];
      end
      for (int k = 0; k < 3; k++) begin
        s1_e1_q[k]  <= e1_d[k];
        s1_e2_q[k]  <= e2_d[k];
        s1_tv_q[k]  <= tv_d[k];
        s1_dir_q[k] <= dir_d[k];
        s2_e1_q[k]  <= s1_e1_q[k];
        s2_e2_q[k]  <= s1_e2_q[k];
        s2_tv_q[k]  <= s1_tv_q[k];
        s2_dir_q[k] <= s1_dir_q[k];
        s2_pa_q[k]  <= pa_d[k];
        s2_pb_q[k]  <= pb_d[k];
        s2_qa_q[k]  <= qa_d[k];
        s2_qb_q[k]  <= qb_d[k];
        s3_e1_q[k]  <= s2_e1_q[k];
        s3_e2_q[k]  <= s2_e2_q[k];
        s3_tv_q[k]  <= s2_tv_q[k];
        s3_dir_q[k] <= s2_dir_q[k];
        s3_p_q[k]   <= s2_pa_q[k] - s2_pb_q[k];
        s3_q_q[k]   <= s2_qa_q[k] - s2_qb_q[k];
      end
      for (int d = 0; d < 4; d++) begin
        for (int k = 0; k < 3; k++) begin
          s4_hp_q[d][k]   <= hp_d[d][k];
          s4_lp_q[d][k]   <= lp_d[d][k];
          s5_term_q[d][k] <= term_d[d][k];
        end
        s6_sum_q[d] <= s5_term_q[d][0] + s5_term_q[d][1] + s5_term_q[d][2];
        s7_n_q[d]   <= s6_sum_q[0][DW-1] ? (~s6_sum_q[d] + 1'b1) : s6_sum_q[d];
      end
      cls_reason_q <= reason_d;
      cls_det_q    <= det;
      cls_nt_q     <= nt;
      cls_rmin_q   <= rmin_q[DEPTH-1];
      cls_rmax_q   <= rmax_q[DEPTH-1];
    end
  end

  assign cls_o = '{valid:  cls_vld_q,
                   reason: cls_reason_q,
                   det:    cls_det_q,
                   nt:     cls_nt_q,
                   rmin:   cls_rmin_q,
                   rmax:   cls_rmax_q};

endmodule

/* sv/rti_divider.sv */
// ----------------------------------------------------------------------------
// rti_divider
// Pipelined restoring division of the scaled t numerator by the
// determinant, one quotient bit per stage, with saturation and range check.
// ----------------------------------------------------------------------------
module rti_divider #(
  parameter int unsigned COORD_FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  rti_pkg::classify_t cls_i,
  output rti_pkg::result_t   res_o
);

  localparam int unsigned DW   = rti_pkg::DOT_W;
  localparam int unsigned QW   = 31;
  localparam int unsigned RW   = DW + COORD_FRAC_BITS + QW + 1;
  localparam int unsigned NSTG = QW + 2;
  localparam logic [31:0] T_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] T_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [RW-1:0]    rem;
    logic [DW-1:0]    den;
    logic [QW-1:0]    quo;
    logic             neg;
    logic             ovf;
    rti_pkg::reason_e reason;
    logic [31:0]      rmin;
    logic [31:0]      rmax;
  } div_t;

  div_t stg_q [NSTG];
  logic vld_q [NSTG];
  div_t s0_d, s1_d;
  div_t step_d [QW];
  logic [DW-1:0] nt_abs;

  div_t             fin;
  logic [31:0]      t_d, t_q;
  rti_pkg::reason_e t_reason_q;
  logic [31:0]      t_rmin_q, t_rmax_q;
  logic             t_vld_q;

  rti_pkg::reason_e res_reason_d, res_reason_q;
  logic [31:0]      res_dist_d, res_dist_q;
  logic             res_vld_q;

  always_comb begin
    nt_abs      = cls_i.nt[DW-1] ? (~cls_i.nt + 1'b1) : cls_i.nt;
    s0_d.rem    = RW'(nt_abs) << COORD_FRAC_BITS;
    s0_d.den    = cls_i.det;
    s0_d.quo    = '0;
    s0_d.neg    = cls_i.nt[DW-1];
    s0_d.ovf    = 1'b0;
    s0_d.reason = cls_i.reason;
    s0_d.rmin   = cls_i.rmin;
    s0_d.rmax   = cls_i.rmax;

    s1_d     = stg_q[0];
    s1_d.ovf = stg_q[0].rem >= (RW'(stg_q[0].den) << QW);
  end

  always_comb begin
    logic [RW-1:0] dsh;
    int            b;
    for (int s = 0; s < QW; s++) begin
      b         = QW - 1 - s;
      step_d[s] = stg_q[s+1];
      dsh       = RW'(stg_q[s+1].den) << b;
      if (stg_q[s+1].rem >= dsh) begin
        step_d[s].rem    = stg_q[s+1].rem - dsh;
        step_d[s].quo[b] = 1'b1;
      end
    end
  end

  always_comb begin
    fin = stg_q[NSTG-1];
    if (fin.ovf) begin
      t_d = fin.neg ? T_MIN : T_MAX;
    end else if (fin.neg) begin
      t_d = ~{1'b0, fin.quo} + 1'b1;
    end else begin
      t_d = {1'b0, fin.quo};
    end
  end

  always_comb begin
    res_reason_d = t_reason_q;
    res_dist_d   = '0;
    if (t_reason_q == rti_pkg::REASON_HIT) begin
      res_dist_d = t_q;
      if ($signed(t_q) < $signed(t_rmin_q) || $signed(t_q) > $signed(t_rmax_q)) begin
        res_reason_d = rti_pkg::REASON_T_OUT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSTG; i++) begin
        vld_q[i] <= 1'b0;
      end
      t_vld_q   <= 1'b0;
      res_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= cls_i.valid;
      for (int i = 1; i < NSTG; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
      t_vld_q   <= vld_q[NSTG-1];
      res_vld_q <= t_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stg_q[0] <= s0_d;
      stg_q[1] <= s1_d;
      for (int s = 0; s < QW; s++) begin
        stg_q[s+2] <= step_d[s];
      end
      t_q          <= t_d;
      t_reason_q   <= fin.reason;
      t_rmin_q     <= fin.rmin;
      t_rmax_q     <= fin.rmax;
      res_reason_q <= res_reason_d;
      res_dist_q   <= res_dist_d;
    end
  end

  assign res_o = '{valid:    res_vld_q,
                   hit:      (res_reason_q == rti_pkg::REASON_HIT),
                   reason:   res_reason_q,
                   distance: res_dist_q};

endmodule

/* tb/ray_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_result_checker
// Watches the item, result and epsilon channels of the intersection engine.
// Keeps a shadow corner store and epsilon, computes the expected outcome of
// every ray test with exact wide arithmetic and compares each result transfer
// field by field against the oldest pending outcome.
// ----------------------------------------------------------------------------
module ray_result_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_tvalid_i,
  input  logic                      s_tready_i,
  input  logic [271:0]              s_tdata_i,
  input  logic [0:0]                s_tuser_i,
  input  logic                      m_tvalid_i,
  input  logic                      m_tready_i,
  input  logic [39:0]               m_tdata_i,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [rti_pkg::EPS_W-1:0] cfg_data_i,
  output int unsigned               fail_count_o,
  output int unsigned               pending_count_o
);

  localparam int COORD_FRAC_BITS_TB = 16;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic                        hit;
    rti_pkg::reason_e            reason;
    logic [rti_pkg::COORD_W-1:0] distance;
  } outcome_t;

  logic [rti_pkg::COORD_W-1:0] shadow_corners [1024*9];
  logic [rti_pkg::EPS_W-1:0]   shadow_eps;
  outcome_t                    outcome_q [$];

  function automatic wide_t sx(logic [31:0] v);
    return wide_t'($signed(v));
  endfunction

  function automatic outcome_t intersect_outcome(logic [271:0] d);
    outcome_t  res;
    int        base;
    wide_t     c0 [3], e1 [3], e2 [3], tv [3], dv [3], pv [3], qv [3];
    wide_t     det, nu, nv, nt, mag, t, eps;
    logic      neg;
    base = int'(d[9:0]) * 9;
    for (int k = 0; k < 3; k++) begin
      c0[k] = sx(shadow_corners[base + k]);
      e1[k] = sx(shadow_corners[base + 3 + k]) - c0[k];
      e2[k] = sx(shadow_corners[base + 6 + k]) - c0[k];
      tv[k] = sx(d[12 + 32*k +: 32]) - c0[k];
      dv[k] = sx(d[108 + 32*k +: 32]);
    end
    pv[0] = dv[1]*e2[2] - dv[2]*e2[1];
    pv[1] = dv[2]*e2[0] - dv[0]*e2[2];
    pv[2] = dv[0]*e2[1] - dv[1]*e2[0];
    qv[0] = tv[1]*e1[2] - tv[2]*e1[1];
    qv[1] = tv[2]*e1[0] - tv[0]*e1[2];
    qv[2] = tv[0]*e1[1] - tv[1]*e1[0];
    det = e1[0]*pv[0] + e1[1]*pv[1] + e1[2]*pv[2];
    nu  = tv[0]*pv[0] + tv[1]*pv[1] + tv[2]*pv[2];
    nv  = dv[0]*qv[0] + dv[1]*qv[1] + dv[2]*qv[2];
    nt  = e2[0]*qv[0] + e2[1]*qv[1] + e2[2]*qv[2];
    if (det < 0) begin
      det = -det; nu = -nu; nv = -nv; nt = -nt;
    end
    eps = wide_t'({65'd0, shadow_eps});
    res.distance = '0;
    if (det == 0 || det < eps) begin
      res.reason = rti_pkg::REASON_PARALLEL;
    end else if (nu < 0 || nu > det) begin
      res.reason = rti_pkg::REASON_U_OUT;
    end else if (nv < 0 || nu + nv > det) begin
      res.reason = rti_pkg::REASON_V_OUT;
    end else begin
      neg = nt < 0;
      mag = (neg ? -nt : nt) <<< COORD_FRAC_BITS_TB;
      t   = mag / det;
      if (neg) t = -t;
      if (t > sx(32'h7fffffff)) t = sx(32'h7fffffff);
      if (t < sx(32'h80000000)) t = sx(32'h80000000);
      res.distance = t[31:0];
      if (t < sx(d[235:204]) || t > sx(d[267:236])) res.reason = rti_pkg::REASON_T_OUT;
      else res.reason = rti_pkg::REASON_HIT;
    end
    res.hit = (res.reason == rti_pkg::REASON_HIT);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t         exp_o;
    rti_pkg::reason_e got_reason;
    int               base;
    if (!rst_ni) begin
      outcome_q.delete();
      shadow_eps      <= rti_pkg::EPS_RESET;
      pending_count_o <= 0;
      fail_count_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) shadow_eps <= cfg_data_i;
      if (s_tvalid_i && s_tready_i) begin
        if (rti_pkg::op_e'(s_tuser_i) == rti_pkg::OP_WRITE) begin
          if (s_tdata_i[11:10] != 2'd3) begin
            base = int'(s_tdata_i[9:0]) * 9 + int'(s_tdata_i[11:10]) * 3;
            for (int k = 0; k < 3; k++) shadow_corners[base + k] = s_tdata_i[12 + 32*k +: 32];
          end
        end else begin
          outcome_q.insert(outcome_q.size(), intersect_outcome(s_tdata_i));
        end
      end
      if (m_tvalid_i && m_tready_i) begin
        if (outcome_q.size() == 0) begin
          $error("result transfer with no pending test: %h", m_tdata_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_o      = outcome_q.pop_front();
          got_reason = rti_pkg::reason_e'(m_tdata_i[3:1]);
          if (m_tdata_i[0] !== exp_o.hit || got_reason !== exp_o.reason ||
              m_tdata_i[35:4] !== exp_o.distance || m_tdata_i[39:36] !== 4'd0) begin
            fail_count_o <= fail_count_o + 1;
            if (m_tdata_i[0] !== exp_o.hit)
              $error("hit expected %0d actual %0d", exp_o.hit, m_tdata_i[0]);
            if (got_reason !== exp_o.reason)
              $error("reject_reason expected %0d actual %0d", exp_o.reason, m_tdata_i[3:1]);
            if (m_tdata_i[35:4] !== exp_o.distance)
              $error("hit_distance expected %h actual %h", exp_o.distance, m_tdata_i[35:4]);
            if (m_tdata_i[39:36] !== 4'd0)
              $error("zero fill expected 0 actual %h", m_tdata_i[39:36]);
          end
        end
      end
      pending_count_o <= outcome_q.size();
    end
  end

endmodule

/* tb/tb_ray_triangle_intersect.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ray_triangle_intersect
// Stimulus and verdict for the ray-triangle intersection engine. Loads
// triangles, runs directed rays through every reject reason, then random
// corner writes, aimed rays and noise rays under several epsilon settings,
// with random stalls on both streams in most phases. A separate checker does the scoring.
// ----------------------------------------------------------------------------
module tb_ray_triangle_intersect;

  localparam logic signed [31:0] ONE = 32'sd65536;
  localparam int CYCLE_LIMIT = 400000;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [271:0]              s_axis_tdata;
  logic [0:0]                s_axis_tuser;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [39:0]               m_axis_tdata;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [rti_pkg::EPS_W-1:0] cfg_data_i;
  int unsigned               fail_count;
  int unsigned               pending_count;
  int unsigned               cycle_count;
  logic                      stall_en;

  logic signed [31:0] tri_copy [1024*9];
  logic [2:0]         corner_mask [1024];
  int                 loaded_q [$];

  ray_triangle_intersect u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  ray_result_checker u_checker (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready),
    .s_tdata_i(s_axis_tdata), .s_tuser_i(s_axis_tuser),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready), .m_tdata_i(m_axis_tdata),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .fail_count_o(fail_count), .pending_count_o(pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= stall_en ? ($urandom_range(99) >= 17) : 1'b1;
  end

  task automatic send(rti_pkg::op_e op, logic [9:0] idx, logic [1:0] cor,
                      logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                      logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                      logic [31:0] rmin, logic [31:0] rmax);
    logic rdy;
    while (stall_en && $urandom_range(99) < 17) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'd0, rmax, rmin, dz, dy, dx, pz, py, px, cor, idx};
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
  endtask

  task automatic write_corner(int idx, logic [1:0] cor, logic [31:0] x,
                              logic [31:0] y, logic [31:0] z);
    send(rti_pkg::OP_WRITE, idx[9:0], cor, x, y, z, $urandom, $urandom, $urandom, $urandom,
         $urandom);
    if (cor != 2'd3) begin
      tri_copy[idx*9 + cor*3]     = x;
      tri_copy[idx*9 + cor*3 + 1] = y;
      tri_copy[idx*9 + cor*3 + 2] = z;
      if (corner_mask[idx] != 3'b111) begin
        corner_mask[idx][cor] = 1'b1;
        if (corner_mask[idx] == 3'b111) loaded_q.insert(loaded_q.size(), idx);
      end
    end
  endtask

  task automatic test_ray(int idx, logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                          logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                          logic [31:0] rmin, logic [31:0] rmax);
    send(rti_pkg::OP_TEST, idx[9:0], 2'($urandom), px, py, pz, dx, dy, dz, rmin, rmax);
  endtask

  function automatic logic [31:0] small_coord();
    return 32'($signed($urandom_range(0, 1 << 23)) - (1 << 22));
  endfunction

  task automatic load_triangle(int idx);
    for (int c = 0; c < 3; c++) write_corner(idx, 2'(c), small_coord(), small_coord(),
                                             small_coord());
  endtask

  // Aim at a point inside the triangle from some distance back along the ray, now and then from beyond it.
  task automatic aimed_ray(int idx);
    longint c0 [3], e1 [3], e2 [3], dv [3], org [3];
    longint a, b, t;
    logic [31:0] rmin, rmax;
    a = $urandom_range(0, 256);
    b = $urandom_range(0, 256 - a);
    t = $urandom_range(0, 64 << 16) - (($urandom_range(9) == 0) ? (8 << 16) : 0);
    for (int k = 0; k < 3; k++) begin
      c0[k]  = tri_copy[idx*9 + k];
      e1[k]  = longint'(tri_copy[idx*9 + 3 + k]) - c0[k];
      e2[k]  = longint'(tri_copy[idx*9 + 6 + k]) - c0[k];
      dv[k]  = longint'($urandom_range(0, 1 << 19)) - (1 << 18);
      org[k] = c0[k] + (a * e1[k] + b * e2[k]) / 256 - ((dv[k] * t) >>> 16);
    end
    case ($urandom_range(3))
      0: begin rmin = 32'h80000000; rmax = 32'h7fffffff; end
      1: begin rmin = 32'(t - $urandom_range(0, 1 << 16)); rmax = 32'(t + $urandom_range(0, 1 << 16)); end
      2: begin rmin = 32'(t + $urandom_range(1, 1 << 16)); rmax = rmin + $urandom_range(0, 1 << 18); end
      default: begin rmin = 32'(t + 1); rmax = 32'(t - 1); end
    endcase
    test_ray(idx, 32'(org[0]), 32'(org[1]), 32'(org[2]),
             32'(dv[0]), 32'(dv[1]), 32'(dv[2]), rmin, rmax);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_epsilon(logic [rti_pkg::EPS_W-1:0] value);
    logic rdy;
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do begin
      @(negedge clk_i);
      rdy = cfg_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_items(int count);
    int idx;
    for (int n = 0; n < count; n++) begin
      idx = loaded_q[$urandom_range(loaded_q.size() - 1)];
      case ($urandom_range(99)) inside
        [0:24]: begin
          if ($urandom_range(3) == 0) idx = $urandom_range(1023);
          if ($urandom_range(4) == 0)
            write_corner(idx, 2'($urandom), $urandom, $urandom, $urandom);
          else
            write_corner(idx, 2'($urandom), small_coord(), small_coord(), small_coord());
        end
        [25:29]: begin
          // collapse a triangle to a single point
          for (int c = 0; c < 3; c++)
            write_corner(idx, 2'(c), tri_copy[idx*9], tri_copy[idx*9+1], tri_copy[idx*9+2]);
        end
        [30:84]: aimed_ray(idx);
        default: test_ray(idx, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom);
      endcase
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    cycle_count   = 0;
    stall_en      = 1'b1;
    for (int i = 0; i < 1024; i++) corner_mask[i] = 3'b000;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // unit triangle in z = 0 and its mirror winding
    write_corner(0, rti_pkg::CORNER_0, 0, 0, 0);
    write_corner(0, rti_pkg::CORNER_1, ONE, 0, 0);
    write_corner(0, rti_pkg::CORNER_2, 0, ONE, 0);
    write_corner(1, rti_pkg::CORNER_0, 0, 0, 0);
    write_corner(1, rti_pkg::CORNER_1, 0, ONE, 0);
    write_corner(1, rti_pkg::CORNER_2, ONE, 0, 0);
    write_corner(1023, rti_pkg::CORNER_0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    write_corner(1023, rti_pkg::CORNER_1, 32'h80000000, 32'h80000000, 32'h80000000);
    write_corner(1023, rti_pkg::CORNER_2, 32'h80000000, 32'h7fffffff, 0);
    write_corner(2, rti_pkg::CORNER_0, ONE, ONE, ONE);
    write_corner(2, rti_pkg::CORNER_1, ONE, ONE, ONE);
    write_corner(2, rti_pkg::CORNER_2, ONE, ONE, ONE);

    test_ray(0, ONE/4, ONE/4, -ONE, 0, 0, ONE, 0, 2*ONE);
    test_ray(1, ONE/4, ONE/4, -ONE, 0, 0, ONE, 0, 2*ONE);
    test_ray(0, ONE/4, ONE/4, -ONE, ONE, 0, 0, 0, 2*ONE);
    test_ray(0, -ONE, ONE/4, -ONE, 0, 0, ONE, 0, 2*ONE);
    test_ray(0, ONE/4, -ONE, -ONE, 0, 0, ONE, 0, 2*ONE);
    test_ray(0, ONE*4/5, ONE*4/5, -ONE, 0, 0, ONE, 0, 2*ONE);
    test_ray(0, ONE/4, ONE/4, -ONE, 0, 0, ONE, 2*ONE, 3*ONE);
    test_ray(0, ONE/4, ONE/4, -ONE, 0, 0, ONE, 2*ONE, 0);
    test_ray(0, ONE/4, ONE/4, ONE, 0, 0, ONE, -2*ONE, 0);
    test_ray(0, 0, 0, -ONE, 0, 0, 1, 32'h80000000, 32'h7fffffff);
    write_corner(0, 2'd3, 32'h7fffffff, 32'h80000000, 32'hffffffff);
    test_ray(0, ONE/4, ONE/4, -ONE, 0, 0, ONE, ONE, ONE);
    test_ray(1023, 32'h80000000, 32'h7fffffff, 32'h80000000,
             32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    test_ray(1023, 0, 0, 0, 32'hffffffff, 32'h00000001, 32'h7fffffff,
             32'h80000000, 32'h7fffffff);
    test_ray(2, 0, 0, 0, ONE, ONE, ONE, 32'h80000000, 32'h7fffffff);
    for (int i = 0; i < 12; i++) load_triangle($urandom_range(3, 1022));

    random_items(330);
    drain();
    set_epsilon('0);
    test_ray(2, 0, 0, 0, ONE, ONE, ONE, 32'h80000000, 32'h7fffffff);
    test_ray(0, ONE/4, ONE/4, -ONE, 0, 0, ONE, 0, 2*ONE);
    stall_en = 1'b0;
    random_items(350);
    drain();
    stall_en = 1'b1;
    set_epsilon({rti_pkg::EPS_W{1'b1}});
    random_items(250);
    drain();
    set_epsilon(rti_pkg::EPS_W'({$urandom, $urandom}) >> $urandom_range(20, 62));
    random_items(300);
    drain();
    set_epsilon(rti_pkg::EPS_RESET);
    random_items(300);
    drain();

    if (fail_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/rti_pkg.sv
sv/rti_corner_store.sv
sv/rti_vector_unit.sv
sv/rti_divider.sv
sv/ray_triangle_intersect.sv
tb/ray_result_checker.sv
tb/tb_ray_triangle_intersect.sv
